[design/bse_pkg.sv]
// Shared types and constants for the bitmap set engine.
package bse_pkg;

  localparam int NUM_SETS_DEF       = 8;
  localparam int UNIVERSE_DEPTH_DEF = 16;

  localparam int CMD_W    = 4;
  localparam int SET_W    = 3;
  localparam int ELEM_W   = 32;
  localparam int UIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 4'd0,
    CMD_CLEAR     = 4'd1,
    CMD_ADD       = 4'd2,
    CMD_DELETE    = 4'd3,
    CMD_MEMBER    = 4'd4,
    CMD_UNION     = 4'd5,
    CMD_INTERSECT = 4'd6,
    CMD_SUBTRACT  = 4'd7,
    CMD_EMPTY     = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_SAME_SET = 2'd1,
    STAT_NO_ELEM  = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

[design/bitmap_set_engine.sv]
// Bitmap set engine: universe table, membership bitmap memory and command sequencer.
// On an accepted start the element is compared against all used universe entries and both
// bitmap rows are read into registers; the execute state then does the bitmap write-back
// and registers the result word, valid while done is high. New commands are accepted only
// while busy is low. The receiver cannot stall: done is high for exactly one cycle.
// Reset (rst, sync, active high) empties every set through per-row valid bits and sets
// universe_size to 0; universe entries are undefined until loaded.
module bitmap_set_engine
#(
  parameter int NUM_SETS       = bse_pkg::NUM_SETS_DEF,
  parameter int UNIVERSE_DEPTH = bse_pkg::UNIVERSE_DEPTH_DEF
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bse_pkg::CMD_W-1:0]     command,
  input  logic [bse_pkg::SET_W-1:0]     first_set,
  input  logic [bse_pkg::SET_W-1:0]     second_set,
  input  logic signed [bse_pkg::ELEM_W-1:0] element,
  input  logic [bse_pkg::UIDX_W-1:0]    universe_index,
  output logic                          done,
  output logic                          member_flag,
  output logic                          empty_flag,
  output logic                          in_universe,
  output logic [bse_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bse_pkg::SIZE_W-1:0]    cfg_data
);
  import bse_pkg::*;

  localparam int SIW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SXW = (SIW > SET_W) ? SIW : SET_W;
  localparam int UIW = (UNIVERSE_DEPTH > 1) ? $clog2(UNIVERSE_DEPTH) : 1;
  localparam int UXW = (UIW > UIDX_W) ? UIW : UIDX_W;

  state_t state;

  logic [SIZE_W-1:0] universe_size;

  // universe table: flops, all entries compared in parallel
  logic [ELEM_W-1:0] univ [UNIVERSE_DEPTH];

  // bitmap memory, one row per set; row_vld clears all sets at reset
  logic [UNIVERSE_DEPTH-1:0] maps [NUM_SETS];
  logic [NUM_SETS-1:0]       row_vld;

  logic [UNIVERSE_DEPTH-1:0] used_mask;
  logic [UNIVERSE_DEPTH-1:0] hits;

  // captured command
  logic [CMD_W-1:0]          cmd_q;
  logic [SET_W-1:0]          a_q;
  logic [SET_W-1:0]          b_q;
  logic [ELEM_W-1:0]         elem_q;
  logic [UIDX_W-1:0]         uidx_q;
  logic [UNIVERSE_DEPTH-1:0] hits_q;
  logic [UNIVERSE_DEPTH-1:0] rd_a;
  logic [UNIVERSE_DEPTH-1:0] rd_b;
  logic                      rd_a_vld;
  logic                      rd_b_vld;

  logic [SXW-1:0] a_in_x;
  logic [SXW-1:0] b_in_x;
  logic [SXW-1:0] a_x;
  logic [UXW-1:0] uidx_x;

  logic                      accept;
  logic [UNIVERSE_DEPTH-1:0] a_val;
  logic [UNIVERSE_DEPTH-1:0] b_val;
  logic                      a_ok;
  logic                      b_ok;
  logic                      load_ok;
  logic                      map_we;
  logic [UNIVERSE_DEPTH-1:0] map_wdata;
  logic                      univ_we;
  logic                      member_next;
  logic                      empty_next;
  logic [STATUS_W-1:0]       status_next;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_EXEC);
  assign cfg_ready = (state == ST_IDLE);

  assign a_in_x = SXW'(first_set);
  assign b_in_x = SXW'(second_set);
  assign a_x    = SXW'(a_q);
  assign uidx_x = UXW'(uidx_q);

  genvar gi;
  generate
    for (gi = 0; gi < UNIVERSE_DEPTH; gi++) begin : g_cmp
      assign used_mask[gi] = (gi < int'(universe_size));
      assign hits[gi]      = used_mask[gi] && (univ[gi] == ELEM_W'(element));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      universe_size <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        universe_size <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // capture and bitmap read, registered when a command is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      a_q      <= first_set;
      b_q      <= second_set;
      elem_q   <= ELEM_W'(element);
      uidx_q   <= universe_index;
      hits_q   <= hits;
      rd_a     <= maps[a_in_x[SIW-1:0]];
      rd_b     <= maps[b_in_x[SIW-1:0]];
      rd_a_vld <= row_vld[a_in_x[SIW-1:0]];
      rd_b_vld <= row_vld[b_in_x[SIW-1:0]];
    end
  end

  assign a_val   = rd_a_vld ? rd_a : '0;
  assign b_val   = rd_b_vld ? rd_b : '0;
  assign a_ok    = (int'(a_q) < NUM_SETS);
  assign b_ok    = (int'(b_q) < NUM_SETS);
  assign load_ok = (int'(uidx_q) < UNIVERSE_DEPTH) && ({1'b0, uidx_q} < universe_size);

  always_comb begin
    map_we      = 1'b0;
    map_wdata   = a_val;
    univ_we     = 1'b0;
    member_next = 1'b0;
    empty_next  = 1'b0;
    status_next = STAT_OK;
    case (cmd_q)
      CMD_LOAD: begin
        if (load_ok) univ_we = 1'b1;
        else status_next = STAT_RANGE;
      end
      CMD_CLEAR: begin
        if (a_ok) begin
          map_we    = 1'b1;
          map_wdata = '0;
        end else begin
          status_next = STAT_RANGE;
        end
      end
      CMD_ADD, CMD_DELETE, CMD_MEMBER: begin
        if (!a_ok) begin
          status_next = STAT_RANGE;
        end else if (hits_q == '0) begin
          status_next = STAT_NO_ELEM;
        end else if (cmd_q == CMD_ADD) begin
          map_we    = 1'b1;
          map_wdata = a_val | hits_q;
        end else if (cmd_q == CMD_DELETE) begin
          map_we    = 1'b1;
          map_wdata = a_val & ~hits_q;
        end else begin
          member_next = ((a_val & hits_q) != '0);
        end
      end
      CMD_UNION, CMD_INTERSECT, CMD_SUBTRACT: begin
        if (!a_ok || !b_ok) begin
          status_next = STAT_RANGE;
        end else if (a_q == b_q) begin
          status_next = STAT_SAME_SET;
        end else begin
          map_we = 1'b1;
          if (cmd_q == CMD_UNION) map_wdata = a_val | b_val;
          else if (cmd_q == CMD_INTERSECT) map_wdata = a_val & b_val;
          else map_wdata = a_val & ~b_val;
        end
      end
      CMD_EMPTY: begin
        if (a_ok) empty_next = ((a_val & used_mask) == '0);
        else status_next = STAT_RANGE;
      end
      default: ;
    endcase
  end

  // write-back
  always_ff @(posedge clk) begin
    if (busy && map_we) begin
      maps[a_x[SIW-1:0]] <= map_wdata;
    end
    if (busy && univ_we) begin
      univ[uidx_x[UIW-1:0]] <= elem_q;
    end
    if (busy) begin
      member_flag <= member_next;
      empty_flag  <= empty_next;
      in_universe <= (hits_q != '0);
      status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (busy && map_we) begin
      row_vld[a_x[SIW-1:0]] <= 1'b1;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding execute cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not enter execute");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("execute did not finish in one cycle");

  a_member_ok: assert property (@(posedge clk) disable iff (rst)
    (done && member_flag) |-> (in_universe && status == STAT_OK && !empty_flag))
    else $error("member hit with inconsistent result word");

endmodule
